>>> hdl/spq_pkg.sv
// Shared types, codes and defaults for the sorted priority queue.
`default_nettype none

package spq_pkg;

  localparam int unsigned DEF_CAPACITY = 16;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned PRIO_W       = 16;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned OCC_W        = 5;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [PRIO_W-1:0] prio_t;

  typedef enum logic {
    MODE_ENQ = 1'b0,
    MODE_DEQ = 1'b1
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic push;
    logic pop;
  } spq_ctrl_t;

endpackage : spq_pkg

`default_nettype wire

>>> hdl/sorted_priority_queue.sv
// Top level of the sorted priority queue: cell chain, entry counter, result register.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------------
//  req     | in        | req_valid_i/req_stall_o | mode_i, item_data_i, item_priority_i
//  res     | out       | res_valid_o/res_stall_i | out_valid_o, out_data_o, status_o,
//          |           |                        | occupancy_o
//
// One request per cycle while req_stall_o is low: every cell compares against the new
// priority in parallel and the whole chain shifts in the cycle of the transfer; the result shows in the next cycle.
// Each request gives exactly one result. req_stall_o is high only while a result waits
// under res_stall_i. Reset empties the queue (counter only, cells are not cleared).
`default_nettype none

module sorted_priority_queue #(
  parameter int unsigned CAPACITY = spq_pkg::DEF_CAPACITY
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       req_valid_i,
  output logic                      req_stall_o,
  input  wire                       mode_i,
  input  spq_pkg::data_t            item_data_i,
  input  spq_pkg::prio_t            item_priority_i,
  output logic                      res_valid_o,
  input  wire                       res_stall_i,
  output logic                      out_valid_o,
  output spq_pkg::data_t            out_data_o,
  output logic [spq_pkg::STATUS_W-1:0] status_o,
  output logic [spq_pkg::OCC_W-1:0]    occupancy_o
);
  import spq_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic             req_acc;
  logic             full, empty;
  spq_ctrl_t        ctrl;
  logic [CNT_W-1:0] count_q, count_d;

  logic             res_valid_q, res_valid_d;
  logic             out_valid_q, out_valid_d;
  data_t            out_data_q, out_data_d;
  status_e          status_q, status_d;
  logic [OCC_W-1:0] occ_q, occ_d;

  data_t cell_data [CAPACITY];
  prio_t cell_prio [CAPACITY];
  logic  cell_take [CAPACITY];

  // A new request is taken unless a finished result is held back downstream.
  assign req_stall_o = res_valid_q && res_stall_i;
  assign req_acc     = req_valid_i && !req_stall_o;

  assign full  = (count_q == CNT_W'(CAPACITY));
  assign empty = (count_q == '0);

  // Chain moves only on a transfer that really changes the queue.
  always_comb begin
    ctrl.push = req_acc && (mode_i == MODE_ENQ) && !full;
    ctrl.pop  = req_acc && (mode_i == MODE_DEQ) && !empty;
  end

  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic  left_take;
      data_t left_data, right_data;
      prio_t left_prio, right_prio;

      if (i == 0) begin : g_head
        assign left_take = 1'b0;
        assign left_data = '0;
        assign left_prio = '0;
      end else begin : g_mid
        assign left_take = cell_take[i-1];
        assign left_data = cell_data[i-1];
        assign left_prio = cell_prio[i-1];
      end

      // Tail cell: whatever it loads on a pop falls outside the count.
      if (i == CAPACITY - 1) begin : g_tail
        assign right_data = cell_data[i];
        assign right_prio = cell_prio[i];
      end else begin : g_inner
        assign right_data = cell_data[i+1];
        assign right_prio = cell_prio[i+1];
      end

      spq_cell u_cell (
        .clk_i        (clk_i),
        .ctrl_i       (ctrl),
        .valid_i      (count_q > CNT_W'(i)),
        .new_data_i   (item_data_i),
        .new_prio_i   (item_priority_i),
        .left_take_i  (left_take),
        .left_data_i  (left_data),
        .left_prio_i  (left_prio),
        .right_data_i (right_data),
        .right_prio_i (right_prio),
        .data_o       (cell_data[i]),
        .prio_o       (cell_prio[i]),
        .take_o       (cell_take[i])
      );
    end
  endgenerate

  always_comb begin
    count_d = count_q;
    if (ctrl.push) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctrl.pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // Result for the request just taken; head data is read before the chain shifts.
  // Occupancy carries the low bits of the count, zero-extended for small capacities.
  always_comb begin
    res_valid_d = res_valid_q && res_stall_i;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    status_d    = status_q;
    occ_d       = occ_q;
    if (req_acc) begin
      res_valid_d = 1'b1;
      out_valid_d = ctrl.pop;
      out_data_d  = ctrl.pop ? cell_data[0] : '0;
      occ_d       = OCC_W'(count_d);
      if (mode_i == MODE_ENQ) begin
        status_d = full ? ST_FULL : ST_OK;
      end else begin
        status_d = empty ? ST_EMPTY : ST_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_valid_q <= out_valid_d;
    out_data_q  <= out_data_d;
    status_q    <= status_d;
    occ_q       <= occ_d;
  end

  assign res_valid_o = res_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign status_o    = status_q;
  assign occupancy_o = occ_q;

  // Checks

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_full_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && (mode_i == MODE_ENQ) && full)
      |=> (status_q == ST_FULL) && $stable(count_q))
    else $error("enqueue into full queue not dropped");

  a_pop_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && (mode_i == MODE_DEQ) && !empty)
      |=> out_valid_q && (count_q == $past(count_q) - CNT_W'(1)))
    else $error("dequeue did not remove the head");

  a_head_sorted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CNT_W'(2)) |-> (cell_prio[0] >= cell_prio[1]))
    else $error("head cells out of priority order");

  a_valid_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && out_valid_q) |-> (status_q == ST_OK))
    else $error("returned entry with non-ok status");

endmodule : sorted_priority_queue

`default_nettype wire

>>> hdl/spq_cell.sv
// One storage cell of the sorted chain: holds an entry and shifts with its neighbors.
`default_nettype none

module spq_cell (
  input  wire                clk_i,
  input  spq_pkg::spq_ctrl_t ctrl_i,
  input  wire                valid_i,
  input  spq_pkg::data_t     new_data_i,
  input  spq_pkg::prio_t     new_prio_i,
  input  wire                left_take_i,
  input  spq_pkg::data_t     left_data_i,
  input  spq_pkg::prio_t     left_prio_i,
  input  spq_pkg::data_t     right_data_i,
  input  spq_pkg::prio_t     right_prio_i,
  output spq_pkg::data_t     data_o,
  output spq_pkg::prio_t     prio_o,
  output logic               take_o
);
  import spq_pkg::*;

  data_t data_q, data_d;
  prio_t prio_q, prio_d;

  // Insert point or beyond: empty slot, or stored priority not above the new one.
  assign take_o = !valid_i || (prio_q <= new_prio_i);

  always_comb begin
    data_d = data_q;
    prio_d = prio_q;
    if (ctrl_i.push) begin
      if (left_take_i) begin
        data_d = left_data_i;
        prio_d = left_prio_i;
      end else if (take_o) begin
        data_d = new_data_i;
        prio_d = new_prio_i;
      end
    end else if (ctrl_i.pop) begin
      data_d = right_data_i;
      prio_d = right_prio_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    prio_q <= prio_d;
  end

  assign data_o = data_q;
  assign prio_o = prio_q;

endmodule : spq_cell

`default_nettype wire

>>> tb/sv/tb_sorted_priority_queue.sv
// Self-checking testbench for the sorted priority queue: stimulus, predictor, checker.
`timescale 1ns / 100ps

module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int unsigned QUEUE_DEPTH  = DEF_CAPACITY;
  localparam int unsigned HOLD_CYCLES  = 80;    // long receiver hold-off
  localparam int unsigned IDLE_LIMIT   = 1000;  // cycles without any transfer
  localparam int unsigned SETTLE_WAIT  = 10;    // quiet cycles after the last result
  localparam int unsigned RANDOM_ITEMS = 1236;

  // Idling profiles; each request carries the one it is sent under.
  typedef enum int unsigned {
    PH_STEADY,
    PH_SEND_GAPS,
    PH_RECV_STALLS,
    PH_BOTH
  } idle_phase_e;

  typedef struct {
    mode_e       mode;
    data_t       data;
    prio_t       prio;
    idle_phase_e phase;
    bit          drain;  // hold back until every result is in
    bit          hold;   // on transfer, the receiver holds off for a long stretch
  } request_t;

  typedef struct {
    logic                 valid;
    data_t                data;
    status_e              status;
    logic [OCC_W-1:0]     occ;
  } result_t;

  int unsigned send_idle_pct[4] = '{0, 55, 0, 26};
  int unsigned recv_stall_pct[4] = '{0, 0, 55, 26};

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 req_valid_i = 1'b0;
  logic                 req_stall_o;
  logic                 mode_i = 1'b0;
  data_t                item_data_i = '0;
  prio_t                item_priority_i = '0;
  logic                 res_valid_o;
  logic                 res_stall_i = 1'b0;
  logic                 out_valid_o;
  data_t                out_data_o;
  logic [STATUS_W-1:0]  status_o;
  logic [OCC_W-1:0]     occupancy_o;

  // Shadow copy of the sorted list, head at index 0.
  data_t       shadow_data [QUEUE_DEPTH];
  prio_t       shadow_prio [QUEUE_DEPTH];
  int          shadow_count = 0;

  request_t    pending_requests[$];
  result_t     expected_results[$];
  request_t    in_flight;
  idle_phase_e cur_phase = PH_STEADY;
  logic        hold_toggle = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned error_count = 0;

  always #1 clk_i = ~clk_i;

  sorted_priority_queue #(
    .CAPACITY(QUEUE_DEPTH)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (req_valid_i),
    .req_stall_o    (req_stall_o),
    .mode_i         (mode_i),
    .item_data_i    (item_data_i),
    .item_priority_i(item_priority_i),
    .res_valid_o    (res_valid_o),
    .res_stall_i    (res_stall_i),
    .out_valid_o    (out_valid_o),
    .out_data_o     (out_data_o),
    .status_o       (status_o),
    .occupancy_o    (occupancy_o)
  );

  // Applies one request to the shadow list and returns the result it must give.
  function automatic result_t predict_result(request_t req);
    result_t res;
    int      pos;
    res.valid  = 1'b0;
    res.data   = '0;
    res.status = ST_OK;
    if (req.mode == MODE_ENQ) begin
      if (shadow_count >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        // In front of the first entry with lower or equal priority: ties go newest first.
        pos = 0;
        while (pos < shadow_count && shadow_prio[pos] > req.prio) pos++;
        for (int k = shadow_count; k > pos; k--) begin
          shadow_data[k] = shadow_data[k-1];
          shadow_prio[k] = shadow_prio[k-1];
        end
        shadow_data[pos] = req.data;
        shadow_prio[pos] = req.prio;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.valid = 1'b1;
      res.data  = shadow_data[0];
      for (int k = 1; k < shadow_count; k++) begin
        shadow_data[k-1] = shadow_data[k];
        shadow_prio[k-1] = shadow_prio[k];
      end
      shadow_count--;
    end
    res.occ = shadow_count[OCC_W-1:0];
    return res;
  endfunction

  function automatic void add_request(mode_e mode, data_t data, prio_t prio,
                                      idle_phase_e phase, bit drain = 1'b0,
                                      bit hold = 1'b0);
    request_t req;
    req.mode  = mode;
    req.data  = data;
    req.prio  = prio;
    req.phase = phase;
    req.drain = drain;
    req.hold  = hold;
    pending_requests.push_back(req);
  endfunction

  // Mix of full-range values, a narrow band for ties, and the extremes.
  function automatic prio_t pick_priority();
    prio_t edges [4] = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff};
    case ($urandom_range(3))
      0:       return prio_t'($urandom_range(6)) - prio_t'(3);
      1:       return edges[$urandom_range(3)];
      default: return prio_t'($urandom);
    endcase
  endfunction

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    end
  endtask

  // Request driver: valid never looks at stall; a stalled payload is held.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_valid_i <= 1'b0;
    end else begin
      if (req_valid_i && !req_stall_o) begin
        expected_results.push_back(predict_result(in_flight));
        if (in_flight.hold) hold_toggle <= ~hold_toggle;
      end
      if (!req_valid_i || !req_stall_o) begin
        if (pending_requests.size() != 0 &&
            !(pending_requests[0].drain && expected_results.size() != 0) &&
            $urandom_range(99) >= send_idle_pct[pending_requests[0].phase]) begin
          in_flight = pending_requests.pop_front();
          req_valid_i     <= 1'b1;
          mode_i          <= in_flight.mode;
          item_data_i     <= in_flight.data;
          item_priority_i <= in_flight.prio;
          cur_phase       <= in_flight.phase;
        end else begin
          req_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result receiver: random stalls per phase, plus a long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_toggle != hold_seen) begin
      hold_seen   <= hold_toggle;
      hold_left   <= HOLD_CYCLES;
      res_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      res_stall_i <= 1'b1;
    end else begin
      res_stall_i <= ($urandom_range(99) < recv_stall_pct[cur_phase]);
    end
  end

  // Result checker: every transfer against the oldest expectation.
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && res_valid_o && !res_stall_i) begin
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, got valid %b data %h status %0d occupancy %0d",
                 $time, out_valid_o, out_data_o, status_o, occupancy_o);
      end else begin
        want = expected_results.pop_front();
        check_field("out_valid", 32'(want.valid), 32'(out_valid_o));
        check_field("out_data", want.data, out_data_o);
        check_field("status", 32'(want.status), 32'(status_o));
        check_field("occupancy", 32'(want.occ), 32'(occupancy_o));
      end
    end
  end

  // Watchdog: too long without a transfer on either channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_valid_i && !req_stall_o) || (res_valid_o && !res_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    idle_phase_e phase;
    int          budget;
    int          count;
    int          len;
    int          kind;
    mode_e       mode;

    // Directed: empty dequeue, extreme data and priorities, a tie, full drain,
    // dequeue fields set to all ones to show they are ignored.
    add_request(MODE_DEQ, '1, '1, PH_STEADY);
    add_request(MODE_ENQ, 32'sh7fffffff, 16'sh7fff, PH_STEADY);
    add_request(MODE_ENQ, 32'sh80000000, 16'sh8000, PH_STEADY);
    add_request(MODE_ENQ, 32'sh00000000, 16'sh0000, PH_STEADY);
    add_request(MODE_ENQ, 32'sh00000001, 16'sh0000, PH_STEADY);
    add_request(MODE_ENQ, 32'shffffffff, 16'shffff, PH_STEADY);
    add_request(MODE_ENQ, 32'sh00000005, 16'sh0001, PH_STEADY);
    repeat (7) add_request(MODE_DEQ, '1, '1, PH_STEADY);

    // Fill past capacity (one drop), then drain past empty.
    repeat (QUEUE_DEPTH + 1)
      add_request(MODE_ENQ, data_t'($urandom), pick_priority(), PH_STEADY);
    repeat (QUEUE_DEPTH + 1)
      add_request(MODE_DEQ, data_t'($urandom), prio_t'($urandom), PH_STEADY);

    // Random part: fill, drain and mixed bursts so the list swings between empty
    // and full, with a little noise of the opposite kind inside each burst.
    budget = RANDOM_ITEMS / 4;
    for (int p = 0; p < 4; p++) begin
      phase = idle_phase_e'(p);
      count = 0;
      while (count < budget) begin
        kind = $urandom_range(9);
        len  = $urandom_range(20, 4);
        for (int i = 0; i < len; i++) begin
          if (kind < 4) mode = ($urandom_range(9) == 0) ? MODE_DEQ : MODE_ENQ;
          else if (kind < 8) mode = ($urandom_range(9) == 0) ? MODE_ENQ : MODE_DEQ;
          else mode = mode_e'($urandom_range(1));
          add_request(mode, data_t'($urandom), pick_priority(), phase, count == 0,
                      (count == 100) && (phase == PH_STEADY || phase == PH_BOTH));
          count++;
        end
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_requests.size() != 0 || req_valid_i) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue.sv
tb/sv/tb_sorted_priority_queue.sv
